/* src/bitplane_signed_mask_unpack_unit_macros.svh */
// assertion macros for the bit-plane signed mask unpack unit
// expects clk_i and rst_ni to be visible where a macro is used
`ifndef BITPLANE_SIGNED_MASK_UNPACK_UNIT_MACROS_SVH
`define BITPLANE_SIGNED_MASK_UNPACK_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define BSMU_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define BSMU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/bsmu_pkg.sv */
// shared constants, codes and types of the bit-plane signed mask unpack unit
// no dependencies
package bsmu_pkg;

  // store geometry
  localparam int NCoefs     = 256;
  localparam int MaxMagBits = 32;
  localparam int PlaneBytes = NCoefs / 8;
  localparam int NPlanes    = MaxMagBits + 1;
  localparam int OffW       = $clog2(PlaneBytes);

  // field widths
  localparam int OpW    = 2;
  localparam int PlaneW = 6;
  localparam int ByteW  = 8;
  localparam int IdxW   = 8;
  localparam int CoefW  = MaxMagBits + 1;
  localparam int MagW   = 6;

  // opcodes
  localparam logic [OpW-1:0] OpWrite    = 2'd0;
  localparam logic [OpW-1:0] OpReadCoef = 2'd1;
  localparam logic [OpW-1:0] OpReadByte = 2'd2;

  // configuration register indexes
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 6;
  localparam logic [CfgIdxW-1:0] CfgMagBits = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgClamp   = 2'd1;

  // request queue depth
  localparam int QDepth = 2;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  typedef enum logic [1:0] {
    KIND_WRITE,
    KIND_COEF,
    KIND_BYTE
  } kind_e;

  // classified request handed from front to back
  typedef struct packed {
    kind_e             kind;
    logic [PlaneW-1:0] plane;
    logic [OffW-1:0]   offset;
    logic [2:0]        bitsel;
    logic [ByteW-1:0]  value;
    logic              addr_ok;
  } cmd_t;

  typedef struct packed {
    logic [MagW-1:0] mag_bits;
    logic            clamp_en;
  } cfg_t;

endpackage

/* src/bsmu_ifs.sv */
// valid/ready channel interfaces: request in, result out, configuration write
// depends on bsmu_pkg
interface bsmu_in_if import bsmu_pkg::*;;
  logic              valid;
  logic              ready;
  logic [OpW-1:0]    opcode;
  logic [PlaneW-1:0] plane;
  logic [OffW-1:0]   byte_offset;
  logic [ByteW-1:0]  byte_value;
  logic [IdxW-1:0]   coef_index;

  modport source (output valid, opcode, plane, byte_offset, byte_value, coef_index,
                  input ready);
  modport sink (input valid, opcode, plane, byte_offset, byte_value, coef_index,
                output ready);
endinterface

interface bsmu_out_if import bsmu_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [CoefW-1:0] coefficient;
  logic [ByteW-1:0]        seed_byte;

  modport source (output valid, coefficient, seed_byte, input ready);
  modport sink (input valid, coefficient, seed_byte, output ready);
endinterface

interface bsmu_cfg_if import bsmu_pkg::*;;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* src/bsmu_front.sv */
// front end: accepts requests, classifies them and holds the config registers
// depends on bsmu_pkg and bsmu_ifs
module bsmu_front import bsmu_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  bsmu_in_if.sink  in_ch_i,
  bsmu_cfg_if.sink cfg_ch_i,
  input  logic full_i,
  output logic push_o,
  output cmd_t cmd_o,
  output cfg_t cfg_o
);

  logic [MagW-1:0] mag_bits_q;
  logic            clamp_en_q;
  logic            addr_ok;
  logic            keep;

  // config writes are always taken
  assign cfg_ch_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mag_bits_q <= MagW'(1);
      clamp_en_q <= 1'b0;
    end else if (cfg_ch_i.valid) begin
      case (cfg_ch_i.index)
        CfgMagBits: mag_bits_q <= cfg_ch_i.data[MagW-1:0];
        CfgClamp:   clamp_en_q <= cfg_ch_i.data[0];
        default: ;
      endcase
    end
  end

  assign cfg_o.mag_bits = mag_bits_q;
  assign cfg_o.clamp_en = clamp_en_q;

  // classify the request
  assign addr_ok = (in_ch_i.plane <= PlaneW'(MaxMagBits));

  always_comb begin
    cmd_o.kind    = KIND_WRITE;
    keep          = 1'b0;
    case (in_ch_i.opcode)
      OpWrite: begin
        cmd_o.kind = KIND_WRITE;
        keep       = addr_ok;
      end
      OpReadCoef: begin
        cmd_o.kind = KIND_COEF;
        keep       = 1'b1;
      end
      OpReadByte: begin
        cmd_o.kind = KIND_BYTE;
        keep       = 1'b1;
      end
      default: keep = 1'b0;
    endcase
    cmd_o.plane   = in_ch_i.plane;
    cmd_o.value   = in_ch_i.byte_value;
    cmd_o.addr_ok = addr_ok;
    // coefficient reads address by index, the others by offset
    if (in_ch_i.opcode == OpReadCoef) begin
      cmd_o.offset = in_ch_i.coef_index[OffW+2:3];
      cmd_o.bitsel = in_ch_i.coef_index[2:0];
    end else begin
      cmd_o.offset = in_ch_i.byte_offset;
      cmd_o.bitsel = 3'd0;
    end
  end

  // dropped requests are still accepted
  assign in_ch_i.ready = !full_i;
  assign push_o        = in_ch_i.valid && !full_i && keep;

endmodule

/* src/bsmu_queue.sv */
// short request queue between front and back end
// depends on bsmu_pkg
module bsmu_queue import bsmu_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t cmd_o
);

  cmd_t             slot_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] count_q, count_d;
  logic             do_pop;

  assign full_o  = (count_q == QCntW'(QDepth));
  assign valid_o = (count_q != '0);
  assign cmd_o   = slot_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // slot storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

/* src/bsmu_back.sv */
// back end: plane-banked seed store, coefficient assembly and result register
// depends on bsmu_pkg, bsmu_ifs and the assertion macros
`include "bitplane_signed_mask_unpack_unit_macros.svh"

module bsmu_back import bsmu_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic q_valid_i,
  input  cmd_t q_cmd_i,
  output logic pop_o,
  input  cfg_t cfg_i,
  bsmu_out_if.source out_ch_o
);

  logic [ByteW-1:0] mem_q [NPlanes][PlaneBytes];
  logic [ByteW-1:0] rd_q  [NPlanes];

  logic              rd_pend_q;
  kind_e             pend_kind_q;
  logic [PlaneW-1:0] pend_plane_q;
  logic [2:0]        pend_bit_q;
  logic              pend_ok_q;

  logic                    out_valid_q;
  logic signed [CoefW-1:0] out_coef_q;
  logic [ByteW-1:0]        out_seed_q;

  logic               is_write;
  logic               rd_go;
  logic [MagW-1:0]    m_act;
  logic [ByteW-1:0]   all_ones;
  logic [ByteW-1:0]   clamp;
  logic [ByteW-1:0]   adj1;
  logic [MaxMagBits-1:0] mag;
  logic [CoefW-1:0]   mag_ext;
  logic [CoefW-1:0]   coef;
  logic [ByteW-1:0]   seed;

  // issue control: a read goes only when the result register will be free
  assign is_write = (q_cmd_i.kind == KIND_WRITE);
  assign rd_go    = q_valid_i && !is_write && !rd_pend_q
                    && (!out_valid_q || out_ch_o.ready);
  assign pop_o    = (q_valid_i && is_write) || rd_go;

  // banked store: one write, all banks read at one offset
  always_ff @(posedge clk_i) begin
    if (q_valid_i && is_write) begin
      mem_q[q_cmd_i.plane][q_cmd_i.offset] <= q_cmd_i.value;
    end
    if (rd_go) begin
      for (int p = 0; p < NPlanes; p++) begin
        rd_q[p] <= mem_q[p][q_cmd_i.offset];
      end
      pend_kind_q  <= q_cmd_i.kind;
      pend_plane_q <= q_cmd_i.plane;
      pend_bit_q   <= q_cmd_i.bitsel;
      pend_ok_q    <= q_cmd_i.addr_ok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_pend_q <= 1'b0;
    end else begin
      rd_pend_q <= rd_go;
    end
  end

  // clamp mask, magnitude gather and sign
  always_comb begin
    m_act = cfg_i.mag_bits;
    if (m_act == '0) begin
      m_act = MagW'(1);
    end else if (m_act > MagW'(MaxMagBits)) begin
      m_act = MagW'(MaxMagBits);
    end
    all_ones = '1;
    for (int p = 1; p <= MaxMagBits; p++) begin
      if (MagW'(p) <= m_act) begin
        all_ones = all_ones & rd_q[p];
      end
    end
    clamp  = cfg_i.clamp_en ? all_ones : '0;
    adj1   = rd_q[1] & ~clamp;
    mag    = '0;
    mag[0] = adj1[pend_bit_q];
    for (int j = 1; j < MaxMagBits; j++) begin
      if (MagW'(j + 1) <= m_act) begin
        mag[j] = rd_q[j + 1][pend_bit_q];
      end
    end
    mag_ext = {1'b0, mag};
    coef    = rd_q[0][pend_bit_q] ? (CoefW'(0) - mag_ext) : mag_ext;
    // byte readback, plane one carries the clamp
    seed = '0;
    if (pend_ok_q) begin
      if (pend_plane_q == PlaneW'(1)) begin
        seed = adj1;
      end else begin
        seed = rd_q[pend_plane_q];
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rd_pend_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ch_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_pend_q) begin
      if (pend_kind_q == KIND_COEF) begin
        out_coef_q <= coef;
        out_seed_q <= '0;
      end else begin
        out_coef_q <= '0;
        out_seed_q <= seed;
      end
    end
  end

  assign out_ch_o.valid       = out_valid_q;
  assign out_ch_o.coefficient = out_coef_q;
  assign out_ch_o.seed_byte   = out_seed_q;

  // checks
  `BSMU_ASSERT_NEXT(a_read_lands, rd_pend_q, out_valid_q, "bank read did not reach result")
  `BSMU_ASSERT_NEXT(a_no_back_to_back, rd_pend_q, !rd_pend_q, "two reads in flight")
  `BSMU_ASSERT_NEXT(a_stall_blocks, out_valid_q && !out_ch_o.ready, !rd_pend_q,
                    "read issued while result stalled")

endmodule

/* src/bitplane_signed_mask_unpack_unit.sv */
// read path: queue slot, bank read register, then result register
// throughput: writes 1 per cycle while the queue is not full; a read issues only once the
// previous read has left the bank read register and the result register is free
// reset: queue, config and result valid clear; store contents stay undefined, no clearing pass
module bitplane_signed_mask_unpack_unit import bsmu_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  bsmu_in_if.sink    in_ch_i,
  bsmu_cfg_if.sink   cfg_ch_i,
  bsmu_out_if.source out_ch_o
);

  cmd_t front_cmd;
  cmd_t q_cmd;
  cfg_t cfg;
  logic push;
  logic full;
  logic q_valid;
  logic pop;

  // request intake and config registers
  bsmu_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_ch_i  (in_ch_i),
    .cfg_ch_i (cfg_ch_i),
    .full_i   (full),
    .push_o   (push),
    .cmd_o    (front_cmd),
    .cfg_o    (cfg)
  );

  // decoupling queue
  bsmu_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .cmd_o   (q_cmd)
  );

  // store and result path
  bsmu_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_cmd_i   (q_cmd),
    .pop_o     (pop),
    .cfg_i     (cfg),
    .out_ch_o  (out_ch_o)
  );

endmodule
